// ===== hdl/xmcr_pkg.sv =====
// ----------------------------------------------------------------------------
// xmcr_pkg
// Shared types and constants for the checksum-mode file receiver.
// ----------------------------------------------------------------------------
package xmcr_pkg;

   // line control bytes
   localparam logic [7:0] BYTE_SOH = 8'h01;
   localparam logic [7:0] BYTE_EOT = 8'h04;
   localparam logic [7:0] BYTE_ACK = 8'h06;
   localparam logic [7:0] BYTE_NAK = 8'h15;
   localparam logic [7:0] BYTE_CAN = 8'h18;
   localparam logic [7:0] BYTE_SUB = 8'h1a;
   localparam logic [7:0] BYTE_CR  = 8'h0d;

   // transfer numbering after a start
   localparam logic [7:0] FIRST_NUMBER   = 8'd1;
   localparam logic [7:0] FIRST_COMPL    = 8'd254;
   localparam logic [7:0] NO_PREV_NUMBER = 8'd200;
   localparam logic [7:0] NO_PREV_COMPL  = 8'd200;

   // request commands
   localparam logic [1:0] CMD_START   = 2'd0;
   localparam logic [1:0] CMD_BYTE    = 2'd1;
   localparam logic [1:0] CMD_TIMEOUT = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_LINE   = 2'd0;
   localparam logic [1:0] KIND_CHUNK  = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;
   localparam logic [1:0] KIND_CANCEL = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SOH,
      ST_NUM,
      ST_CNUM,
      ST_BODY,
      ST_SUM,
      ST_PURGE,
      ST_DONE,
      ST_CANCEL,
      ST_EOT_END,
      ST_SCAN_RD,
      ST_SCAN_USE,
      ST_SCAN_END,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic       clear;
      logic       set_dup;
      logic       clr_dup;
      logic       body_start;
      logic       body_write;
      logic       advance;
      logic       push;
      logic [1:0] push_kind;
      logic [7:0] push_line;
      logic       scan_start;
      logic       scan_rd;
      logic       scan_use;
      logic       acc_push;
      logic       flush;
   } ctl_type;

   typedef struct packed {
      logic out_free;
      logic is_soh;
      logic is_eot;
      logic is_can;
      logic eq_exp_num;
      logic eq_prev_num;
      logic cpl_ok;
      logic eq_sum;
      logic idx_last;
      logic scan_hit;
   } stat_type;

endpackage

// ===== hdl/xmcr_datapath.sv =====
// ----------------------------------------------------------------------------
// xmcr_datapath
// Frame store, numbering, checksum, chunk packing and the result registers.
// ----------------------------------------------------------------------------
module xmcr_datapath #(
   parameter int BLOCK_BYTES = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   input  logic [7:0]        rx_byte,
   input  xmcr_pkg::ctl_type ctl,
   output xmcr_pkg::stat_type stat,
   input  logic              rsp_tready,
   output logic              rsp_tvalid,
   output logic [79:0]       rsp_tdata,
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tlast
);

   localparam int IW = $clog2(BLOCK_BYTES);

   logic [7:0] mem [BLOCK_BYTES];

   logic          text_mode_ff;
   logic [7:0]    exp_num_ff, exp_num_in;
   logic [7:0]    exp_cpl_ff;
   logic [7:0]    prev_num_ff;
   logic [7:0]    prev_cpl_ff;
   logic          dup_ff;
   logic          end_ff;
   logic          send_ff;
   logic [IW-1:0] idx_ff;
   logic [7:0]    sum_ff;
   logic [7:0]    rd_ff;
   logic [63:0]   acc_ff, acc_app;
   logic [2:0]    cnt_ff;

   logic          stg_v_ff;
   logic [1:0]    stg_kind_ff;
   logic [7:0]    stg_line_ff;
   logic [63:0]   stg_chunk_ff;
   logic [3:0]    stg_cnt_ff;

   logic          out_v_ff;
   logic [1:0]    out_kind_ff;
   logic [7:0]    out_line_ff;
   logic [63:0]   out_chunk_ff;
   logic [3:0]    out_cnt_ff;
   logic          out_last_ff;

   logic          keep;
   logic          chunk_full;
   logic          acc_out;
   logic          do_push;
   logic [1:0]    item_kind;
   logic [7:0]    item_line;
   logic [63:0]   item_chunk;
   logic [3:0]    item_cnt;

   assign exp_num_in = exp_num_ff + 8'd1;

   // byte lane insert for the chunk being packed
   always_comb begin
      acc_app = acc_ff;
      for (int i = 0; i < 8; i++) begin
         if (cnt_ff == 3'(i)) acc_app[8*i +: 8] = rd_ff;
      end
   end

   assign keep       = !(text_mode_ff && rd_ff == xmcr_pkg::BYTE_CR);
   assign chunk_full = ctl.scan_use && !stat.scan_hit && keep && send_ff && cnt_ff == 3'd7;
   assign acc_out    = ctl.acc_push && send_ff && cnt_ff != 3'd0;
   assign do_push    = ctl.push || chunk_full || acc_out;

   always_comb begin
      item_kind  = ctl.push_kind;
      item_line  = ctl.push_line;
      item_chunk = '0;
      item_cnt   = '0;
      if (chunk_full) begin
         item_kind  = xmcr_pkg::KIND_CHUNK;
         item_line  = '0;
         item_chunk = acc_app;
         item_cnt   = 4'd8;
      end else if (acc_out) begin
         item_kind  = xmcr_pkg::KIND_CHUNK;
         item_line  = '0;
         item_chunk = acc_ff;
         item_cnt   = {1'b0, cnt_ff};
      end
   end

   always_comb begin
      stat.out_free    = !out_v_ff || rsp_tready;
      stat.is_soh      = rx_byte == xmcr_pkg::BYTE_SOH;
      stat.is_eot      = rx_byte == xmcr_pkg::BYTE_EOT;
      stat.is_can      = rx_byte == xmcr_pkg::BYTE_CAN;
      stat.eq_exp_num  = rx_byte == exp_num_ff;
      stat.eq_prev_num = rx_byte == prev_num_ff;
      stat.cpl_ok      = rx_byte == exp_cpl_ff || (dup_ff && rx_byte == prev_cpl_ff);
      stat.eq_sum      = rx_byte == sum_ff;
      stat.idx_last    = idx_ff == IW'(BLOCK_BYTES - 1);
      stat.scan_hit    = text_mode_ff && !end_ff && rd_ff == xmcr_pkg::BYTE_SUB;
   end

   always_ff @(posedge clock) begin
      if (ctl.body_write) mem[idx_ff] <= rx_byte;
      if (ctl.scan_rd) rd_ff <= mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         text_mode_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         exp_num_ff  <= xmcr_pkg::FIRST_NUMBER;
         exp_cpl_ff  <= xmcr_pkg::FIRST_COMPL;
         prev_num_ff <= xmcr_pkg::NO_PREV_NUMBER;
         prev_cpl_ff <= xmcr_pkg::NO_PREV_COMPL;
         dup_ff      <= 1'b0;
         end_ff      <= 1'b0;
      end else begin
         if (ctl.set_dup) dup_ff <= 1'b1;
         if (ctl.clr_dup) dup_ff <= 1'b0;
         if (ctl.advance && !dup_ff) begin
            prev_num_ff <= exp_num_ff;
            prev_cpl_ff <= exp_cpl_ff;
            exp_num_ff  <= exp_num_in;
            exp_cpl_ff  <= ~exp_num_in;
         end
         if (ctl.scan_use && stat.scan_hit) end_ff <= 1'b1;
      end
   end

   // shared index: body fill, then scan
   always_ff @(posedge clock) begin
      if (ctl.body_start || ctl.scan_start) begin
         idx_ff <= '0;
      end else if (ctl.body_write || (ctl.scan_use && !stat.scan_hit)) begin
         idx_ff <= idx_ff + IW'(1);
      end
      if (ctl.body_start) begin
         sum_ff <= '0;
      end else if (ctl.body_write) begin
         sum_ff <= sum_ff + rx_byte;
      end
      if (ctl.scan_start) send_ff <= !end_ff && !dup_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.scan_start || chunk_full || acc_out) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else if (ctl.scan_use && !stat.scan_hit && keep && send_ff) begin
         acc_ff <= acc_app;
         cnt_ff <= cnt_ff + 3'd1;
      end
   end

   // one held word ahead of the output register, so the last flag is known
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (do_push) begin
         stg_v_ff <= 1'b1;
         if (stg_v_ff) out_v_ff <= 1'b1;
         else if (rsp_tready) out_v_ff <= 1'b0;
      end else if (ctl.flush) begin
         stg_v_ff <= 1'b0;
         out_v_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         stg_kind_ff  <= item_kind;
         stg_line_ff  <= item_line;
         stg_chunk_ff <= item_chunk;
         stg_cnt_ff   <= item_cnt;
      end
      if ((do_push && stg_v_ff) || ctl.flush) begin
         out_kind_ff  <= stg_kind_ff;
         out_line_ff  <= stg_line_ff;
         out_chunk_ff <= stg_chunk_ff;
         out_cnt_ff   <= stg_cnt_ff;
         out_last_ff  <= ctl.flush;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {4'b0, out_cnt_ff, out_chunk_ff, out_line_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (do_push && stg_v_ff) |-> (!out_v_ff || rsp_tready))
      else $error("held word pushed over an untaken result");
   a_flush_held: assert property (@(posedge clock) disable iff (reset)
      ctl.flush |-> stg_v_ff)
      else $error("flush with no held word");
   a_read_once: assert property (@(posedge clock) disable iff (reset)
      ctl.scan_rd |=> !ctl.scan_rd)
      else $error("scan byte read twice without being used");
`endif

endmodule

// ===== hdl/xmcr_controller.sv =====
// ----------------------------------------------------------------------------
// xmcr_controller
// Protocol phases and the sequencing of the per-frame drain.
// ----------------------------------------------------------------------------
module xmcr_controller (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [1:0]         req_tuser,
   input  xmcr_pkg::stat_type stat,
   output xmcr_pkg::ctl_type  ctl
);

   xmcr_pkg::state_type state_ff, state_in;
   xmcr_pkg::state_type ret_ff, ret_in;
   logic take;

   assign req_tready = state_ff inside {xmcr_pkg::ST_IDLE, xmcr_pkg::ST_SOH,
      xmcr_pkg::ST_NUM, xmcr_pkg::ST_CNUM, xmcr_pkg::ST_BODY, xmcr_pkg::ST_SUM,
      xmcr_pkg::ST_PURGE, xmcr_pkg::ST_DONE, xmcr_pkg::ST_CANCEL};
   assign take = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= xmcr_pkg::ST_IDLE;
         ret_ff   <= xmcr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      if (take) begin
         case (req_tuser)
            xmcr_pkg::CMD_START: begin
               state_in = xmcr_pkg::ST_FLUSH;
               ret_in   = xmcr_pkg::ST_SOH;
            end
            xmcr_pkg::CMD_TIMEOUT: begin
               if (state_ff == xmcr_pkg::ST_PURGE) begin
                  state_in = xmcr_pkg::ST_FLUSH;
                  ret_in   = xmcr_pkg::ST_SOH;
               end else if (state_ff inside {xmcr_pkg::ST_SOH, xmcr_pkg::ST_NUM,
                  xmcr_pkg::ST_CNUM, xmcr_pkg::ST_BODY, xmcr_pkg::ST_SUM}) begin
                  state_in = xmcr_pkg::ST_PURGE;
               end
            end
            xmcr_pkg::CMD_BYTE: begin
               case (state_ff)
                  xmcr_pkg::ST_SOH: begin
                     if (stat.is_can) begin
                        state_in = xmcr_pkg::ST_FLUSH;
                        ret_in   = xmcr_pkg::ST_CANCEL;
                     end else if (stat.is_eot) begin
                        state_in = xmcr_pkg::ST_EOT_END;
                     end else if (stat.is_soh) begin
                        state_in = xmcr_pkg::ST_NUM;
                     end else begin
                        state_in = xmcr_pkg::ST_PURGE;
                     end
                  end
                  xmcr_pkg::ST_NUM: begin
                     state_in = (stat.eq_exp_num || stat.eq_prev_num) ?
                        xmcr_pkg::ST_CNUM : xmcr_pkg::ST_PURGE;
                  end
                  xmcr_pkg::ST_CNUM: begin
                     state_in = stat.cpl_ok ? xmcr_pkg::ST_BODY : xmcr_pkg::ST_PURGE;
                  end
                  xmcr_pkg::ST_BODY: begin
                     if (stat.idx_last) state_in = xmcr_pkg::ST_SUM;
                  end
                  xmcr_pkg::ST_SUM: begin
                     if (stat.eq_sum) begin
                        state_in = xmcr_pkg::ST_SCAN_RD;
                        ret_in   = xmcr_pkg::ST_SOH;
                     end else begin
                        state_in = xmcr_pkg::ST_PURGE;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end else begin
         case (state_ff)
            xmcr_pkg::ST_EOT_END: begin
               if (stat.out_free) begin
                  state_in = xmcr_pkg::ST_FLUSH;
                  ret_in   = xmcr_pkg::ST_DONE;
               end
            end
            xmcr_pkg::ST_SCAN_RD: state_in = xmcr_pkg::ST_SCAN_USE;
            xmcr_pkg::ST_SCAN_USE: begin
               if (stat.out_free) begin
                  state_in = (stat.scan_hit || stat.idx_last) ?
                     xmcr_pkg::ST_SCAN_END : xmcr_pkg::ST_SCAN_RD;
               end
            end
            xmcr_pkg::ST_SCAN_END: begin
               if (stat.out_free) state_in = xmcr_pkg::ST_FLUSH;
            end
            xmcr_pkg::ST_FLUSH: begin
               if (stat.out_free) state_in = ret_ff;
            end
            default: ;
         endcase
      end
   end

   // commands
   always_comb begin
      ctl = '0;
      if (take) begin
         case (req_tuser)
            xmcr_pkg::CMD_START: begin
               ctl.clear     = 1'b1;
               ctl.push      = 1'b1;
               ctl.push_kind = xmcr_pkg::KIND_LINE;
               ctl.push_line = xmcr_pkg::BYTE_NAK;
            end
            xmcr_pkg::CMD_TIMEOUT: begin
               if (state_ff == xmcr_pkg::ST_PURGE) begin
                  ctl.push      = 1'b1;
                  ctl.push_kind = xmcr_pkg::KIND_LINE;
                  ctl.push_line = xmcr_pkg::BYTE_NAK;
               end
            end
            xmcr_pkg::CMD_BYTE: begin
               case (state_ff)
                  xmcr_pkg::ST_SOH: begin
                     if (stat.is_can) begin
                        ctl.push      = 1'b1;
                        ctl.push_kind = xmcr_pkg::KIND_CANCEL;
                     end else if (stat.is_eot) begin
                        ctl.push      = 1'b1;
                        ctl.push_kind = xmcr_pkg::KIND_LINE;
                        ctl.push_line = xmcr_pkg::BYTE_ACK;
                     end
                  end
                  xmcr_pkg::ST_NUM: begin
                     if (stat.eq_exp_num) ctl.clr_dup = 1'b1;
                     else if (stat.eq_prev_num) ctl.set_dup = 1'b1;
                  end
                  xmcr_pkg::ST_CNUM: ctl.body_start = stat.cpl_ok;
                  xmcr_pkg::ST_BODY: ctl.body_write = 1'b1;
                  xmcr_pkg::ST_SUM: begin
                     if (stat.eq_sum) begin
                        ctl.push       = 1'b1;
                        ctl.push_kind  = xmcr_pkg::KIND_LINE;
                        ctl.push_line  = xmcr_pkg::BYTE_ACK;
                        ctl.advance    = 1'b1;
                        ctl.scan_start = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
            default: ;
         endcase
      end else begin
         case (state_ff)
            xmcr_pkg::ST_EOT_END: begin
               if (stat.out_free) begin
                  ctl.push      = 1'b1;
                  ctl.push_kind = xmcr_pkg::KIND_DONE;
               end
            end
            xmcr_pkg::ST_SCAN_RD:  ctl.scan_rd  = 1'b1;
            xmcr_pkg::ST_SCAN_USE: ctl.scan_use = stat.out_free;
            xmcr_pkg::ST_SCAN_END: ctl.acc_push = stat.out_free;
            xmcr_pkg::ST_FLUSH:    ctl.flush    = stat.out_free;
            default: ;
         endcase
      end
   end

endmodule

// ===== hdl/xmodem_checksum_receiver_top.sv =====
// ----------------------------------------------------------------------------
// xmodem_checksum_receiver_top
// Checksum-mode block file receiver: line events in, replies and data out.
// ----------------------------------------------------------------------------
// req channel: one word per line event; tuser is the command (start, received
// byte, timeout), tdata the byte. rsp channel: one word per result; tuser is
// the kind (line byte, data chunk, complete, cancelled), tlast marks the last
// word caused by one request word.
// req_tready stays high while a frame is being received, so header and body
// bytes stream at one per clock. A start, a NAK after purge, CAN or EOT puts
// its results in the held word and releases them through the flush state;
// no request is taken meanwhile.
// A good checksum drains the frame store through its single read port, with
// a read state and a use state per stored byte, ending early when text mode
// meets a SUB byte; no further request is taken during the drain.
// Results pass a held word and an output register, so a stalled rsp side
// stalls the drain and the flush but never loses a word.
// Reset clears the protocol to idle and text mode to off; no result is made
// until a start command. The frame store needs no clearing.
// ----------------------------------------------------------------------------
module xmodem_checksum_receiver_top #(
   parameter int BLOCK_BYTES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,   // text_mode
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // rx_byte
   input  logic [1:0]  req_tuser,     // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,     // line_byte, chunk, chunk_count, zero pad
   output logic [1:0]  rsp_tuser,     // out_kind
   output logic        rsp_tlast
);

   xmcr_pkg::ctl_type  ctl;
   xmcr_pkg::stat_type stat;

   xmcr_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .stat       (stat),
      .ctl        (ctl)
   );

   xmcr_datapath #(
      .BLOCK_BYTES (BLOCK_BYTES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rx_byte     (req_tdata),
      .ctl         (ctl),
      .stat        (stat),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
